// ===== design/cpla_pkg.sv =====
// ----------------------------------------------------------------------------
// cpla_pkg
// Shared types, register indexes, reason and source codes for the charger
// power limit arbiter.
// ----------------------------------------------------------------------------
package cpla_pkg;

  localparam int FIELD_W  = 14;
  localparam int REASON_W = 3;
  localparam int CODE_W   = 8;
  localparam int CFG_IDX_W = 2;
  localparam int DC_W     = 2 * FIELD_W;
  localparam int CW_W     = 21;            // centiwatt setpoint width

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_CHARGE_ENABLED     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_AC_POWER_W     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_VOLTAGE_LIMIT_DV   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_HARDWARE_CEILING_W = 2'd3;

  localparam logic [FIELD_W-1:0] RST_MAX_AC_POWER_W     = 14'd2000;
  localparam logic [FIELD_W-1:0] RST_VOLTAGE_LIMIT_DV   = 14'd4010;
  localparam logic [FIELD_W-1:0] RST_HARDWARE_CEILING_W = 14'd10000;

  // limit reasons
  localparam logic [REASON_W-1:0] R_HW      = 3'd0;
  localparam logic [REASON_W-1:0] R_NO_PLUG = 3'd1;
  localparam logic [REASON_W-1:0] R_DISABLE = 3'd2;
  localparam logic [REASON_W-1:0] R_BMS     = 3'd3;
  localparam logic [REASON_W-1:0] R_DC      = 3'd4;
  localparam logic [REASON_W-1:0] R_AC      = 3'd5;
  localparam logic [REASON_W-1:0] R_VOLT    = 3'd6;

  // setpoint source
  localparam logic [1:0] SRC_ZERO = 2'd0;
  localparam logic [1:0] SRC_CEIL = 2'd1;
  localparam logic [1:0] SRC_DC   = 2'd2;
  localparam logic [1:0] SRC_AC   = 2'd3;

  localparam logic [6:0]        CENTI     = 7'd100;
  localparam logic [CODE_W-1:0] CODE_BASE = 8'h64;
  localparam logic [CODE_W-1:0] CODE_MAX  = 8'hA0;
  localparam int                WATTS_PER_STEP = 58;
  localparam logic [FIELD_W-1:0] SAT_W =
    FIELD_W'((int'(CODE_MAX) - int'(CODE_BASE)) * WATTS_PER_STEP);

  // reciprocal constants: x/100 for x < 2^21, x/58 for x < 2^14
  localparam int DIV100_SH = 28;
  localparam logic [21:0] DIV100_M = 22'd2684355;
  localparam int DIV58_SH = 18;
  localparam logic [12:0] DIV58_M = 13'd4520;

  typedef struct packed {
    logic               charge_enabled;
    logic [FIELD_W-1:0] max_ac_power_w;
    logic [FIELD_W-1:0] voltage_limit_dv;
    logic [FIELD_W-1:0] hardware_ceiling_w;
  } cfg_t;

  typedef struct packed {
    logic [DC_W-1:0]     dc_cw;
    logic [CW_W-1:0]     ceil_cw;
    logic [CW_W-1:0]     ac_cw;
    logic [FIELD_W-1:0]  ceil_w;
    logic [FIELD_W-1:0]  ac_w;
    logic [REASON_W-1:0] reason;
    logic                force_zero;
    logic                volt_trip;
  } prod_t;

  typedef struct packed {
    logic [1:0]          src;
    logic [REASON_W-1:0] reason;
    logic [CW_W-1:0]     dc_cw;
    logic [FIELD_W-1:0]  ceil_w;
    logic [FIELD_W-1:0]  ac_w;
  } lim_t;

endpackage

// ===== design/cpla_in_if.sv =====
// ----------------------------------------------------------------------------
// cpla_in_if
// Request channel: battery measurements and permit flags.
// ----------------------------------------------------------------------------
interface cpla_in_if import cpla_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [FIELD_W-1:0] battery_voltage_dv;
  logic [FIELD_W-1:0] current_limit_da;
  logic               plug_present;
  logic               bms_permits;

  modport source (output valid, battery_voltage_dv, current_limit_da, plug_present,
                  bms_permits, input ready);
  modport sink   (input valid, battery_voltage_dv, current_limit_da, plug_present,
                  bms_permits, output ready);
endinterface

// ===== design/cpla_out_if.sv =====
// ----------------------------------------------------------------------------
// cpla_out_if
// Result channel: setpoint, limit reason and charger code.
// ----------------------------------------------------------------------------
interface cpla_out_if import cpla_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [FIELD_W-1:0]  power_setpoint_w;
  logic [REASON_W-1:0] limit_reason;
  logic [CODE_W-1:0]   charger_code;

  modport source (output valid, power_setpoint_w, limit_reason, charger_code,
                  input ready);
  modport sink   (input valid, power_setpoint_w, limit_reason, charger_code,
                  output ready);
endinterface

// ===== design/cpla_cfg_if.sv =====
// ----------------------------------------------------------------------------
// cpla_cfg_if
// Register write channel.
// ----------------------------------------------------------------------------
interface cpla_cfg_if import cpla_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [FIELD_W-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== design/cpla_prod_stage.sv =====
// ----------------------------------------------------------------------------
// cpla_prod_stage
// Stage 1: DC power product, scaled limits, forced-zero checks, voltage trip.
// ----------------------------------------------------------------------------
module cpla_prod_stage import cpla_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  cfg_t               cfg,
  input  logic               valid_i,
  output logic               ready_o,
  input  logic [FIELD_W-1:0] volt_i,
  input  logic [FIELD_W-1:0] amps_i,
  input  logic               plug_i,
  input  logic               bms_i,
  output logic               valid_o,
  input  logic               ready_i,
  output prod_t              data_o
);

  logic  v_r, v_nxt;
  prod_t d_r, d_nxt;

  assign ready_o = !v_r || ready_i;

  always_comb begin
    v_nxt = ready_o ? valid_i : v_r;
    d_nxt.dc_cw   = DC_W'(volt_i) * DC_W'(amps_i);
    d_nxt.ceil_cw = CW_W'(cfg.hardware_ceiling_w) * CW_W'(CENTI);
    d_nxt.ac_cw   = CW_W'(cfg.max_ac_power_w) * CW_W'(CENTI);
    d_nxt.ceil_w  = cfg.hardware_ceiling_w;
    d_nxt.ac_w    = cfg.max_ac_power_w;
    d_nxt.reason  = R_HW;
    if (!plug_i)             d_nxt.reason = R_NO_PLUG;
    if (!cfg.charge_enabled) d_nxt.reason = R_DISABLE;
    if (!bms_i)              d_nxt.reason = R_BMS;
    d_nxt.force_zero = !plug_i || !cfg.charge_enabled || !bms_i;
    d_nxt.volt_trip  = volt_i >= cfg.voltage_limit_dv;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else begin
      v_r <= v_nxt;
    end
    if (ready_o) begin
      d_r <= d_nxt;
    end
  end

  assign valid_o = v_r;
  assign data_o  = d_r;

endmodule

// ===== design/cpla_limit_stage.sv =====
// ----------------------------------------------------------------------------
// cpla_limit_stage
// Stage 2: DC and AC caps in centiwatts, voltage cutoff, source select.
// ----------------------------------------------------------------------------
module cpla_limit_stage import cpla_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  valid_i,
  output logic  ready_o,
  input  prod_t data_i,
  output logic  valid_o,
  input  logic  ready_i,
  output lim_t  data_o
);

  logic            v_r, v_nxt;
  lim_t            d_r, d_nxt;
  logic [DC_W-1:0] sp;

  assign ready_o = !v_r || ready_i;

  always_comb begin
    v_nxt        = ready_o ? valid_i : v_r;
    d_nxt.reason = data_i.reason;
    d_nxt.src    = data_i.force_zero ? SRC_ZERO : SRC_CEIL;
    sp           = data_i.force_zero ? '0 : DC_W'(data_i.ceil_cw);
    if (data_i.dc_cw < sp) begin
      sp           = data_i.dc_cw;
      d_nxt.src    = SRC_DC;
      d_nxt.reason = R_DC;
    end
    if (DC_W'(data_i.ac_cw) < sp) begin
      d_nxt.src    = SRC_AC;
      d_nxt.reason = R_AC;
    end
    if (data_i.volt_trip) begin
      d_nxt.src    = SRC_ZERO;
      d_nxt.reason = R_VOLT;
    end
    // dc is below the ceiling whenever it is selected
    d_nxt.dc_cw  = data_i.dc_cw[CW_W-1:0];
    d_nxt.ceil_w = data_i.ceil_w;
    d_nxt.ac_w   = data_i.ac_w;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else begin
      v_r <= v_nxt;
    end
    if (ready_o) begin
      d_r <= d_nxt;
    end
  end

  assign valid_o = v_r;
  assign data_o  = d_r;

endmodule

// ===== design/cpla_scale_stage.sv =====
// ----------------------------------------------------------------------------
// cpla_scale_stage
// Stages 3 and 4: centiwatts to watts, then watts to saturated charger code.
// Stage 4 is the output register.
// ----------------------------------------------------------------------------
module cpla_scale_stage import cpla_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                valid_i,
  output logic                ready_o,
  input  lim_t                data_i,
  output logic                valid_o,
  input  logic                ready_i,
  output logic [FIELD_W-1:0]  setpoint_o,
  output logic [REASON_W-1:0] reason_o,
  output logic [CODE_W-1:0]   code_o
);

  localparam int P100_W = CW_W + 22;
  localparam int P58_W  = FIELD_W + 13;

  // stage 3
  logic                w_v_r, w_v_nxt;
  logic [FIELD_W-1:0]  watt_r, watt_nxt;
  logic [REASON_W-1:0] w_reason_r;
  logic [P100_W-1:0]   p100;
  logic                w_ready;

  // stage 4
  logic                o_v_r, o_v_nxt;
  logic [FIELD_W-1:0]  o_watt_r;
  logic [REASON_W-1:0] o_reason_r;
  logic [CODE_W-1:0]   o_code_r, o_code_nxt;
  logic [P58_W-1:0]    p58;
  logic [8:0]          q58;

  assign w_ready = !o_v_r || ready_i;
  assign ready_o = !w_v_r || w_ready;

  always_comb begin
    w_v_nxt = ready_o ? valid_i : w_v_r;
    p100    = P100_W'(data_i.dc_cw) * P100_W'(DIV100_M);
    case (data_i.src)
      SRC_CEIL: watt_nxt = data_i.ceil_w;
      SRC_AC:   watt_nxt = data_i.ac_w;
      SRC_DC:   watt_nxt = p100[DIV100_SH+FIELD_W-1:DIV100_SH];
      default:  watt_nxt = '0;
    endcase
  end

  always_comb begin
    o_v_nxt = w_ready ? w_v_r : o_v_r;
    p58     = P58_W'(watt_r) * P58_W'(DIV58_M);
    q58     = p58[P58_W-1:DIV58_SH];
    if (watt_r >= SAT_W) begin
      o_code_nxt = CODE_MAX;
    end else begin
      o_code_nxt = CODE_BASE + CODE_W'(q58);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_v_r <= 1'b0;
      o_v_r <= 1'b0;
    end else begin
      w_v_r <= w_v_nxt;
      o_v_r <= o_v_nxt;
    end
    if (ready_o) begin
      watt_r     <= watt_nxt;
      w_reason_r <= data_i.reason;
    end
    if (w_ready) begin
      o_watt_r   <= watt_r;
      o_reason_r <= w_reason_r;
      o_code_r   <= o_code_nxt;
    end
  end

  assign valid_o    = o_v_r;
  assign setpoint_o = o_watt_r;
  assign reason_o   = o_reason_r;
  assign code_o     = o_code_r;

endmodule

// ===== design/charger_power_limit_arbiter_top.sv =====
// ----------------------------------------------------------------------------
// charger_power_limit_arbiter_top
// Throughput: one request per cycle while the result side accepts; four
// register stages (product, limit select, divide by 100, code scaling),
// each stalls only when full downstream.
// Reset: synchronous, active low; clears stage valids and loads register
// defaults (enabled, 2000 W AC, 401.0 V cutoff, 10000 W ceiling).
// ----------------------------------------------------------------------------
module charger_power_limit_arbiter_top import cpla_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  cpla_in_if.sink   in_ch,
  cpla_out_if.source out_ch,
  cpla_cfg_if.sink  cfg_ch
);

  cfg_t  cfg_r, cfg_nxt;
  logic  p_valid, p_ready;
  prod_t p_data;
  logic  l_valid, l_ready;
  lim_t  l_data;

  assign cfg_ch.ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        REG_CHARGE_ENABLED:     cfg_nxt.charge_enabled     = cfg_ch.data[0];
        REG_MAX_AC_POWER_W:     cfg_nxt.max_ac_power_w     = cfg_ch.data;
        REG_VOLTAGE_LIMIT_DV:   cfg_nxt.voltage_limit_dv   = cfg_ch.data;
        REG_HARDWARE_CEILING_W: cfg_nxt.hardware_ceiling_w = cfg_ch.data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.charge_enabled     <= 1'b1;
      cfg_r.max_ac_power_w     <= RST_MAX_AC_POWER_W;
      cfg_r.voltage_limit_dv   <= RST_VOLTAGE_LIMIT_DV;
      cfg_r.hardware_ceiling_w <= RST_HARDWARE_CEILING_W;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  cpla_prod_stage u_prod (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .valid_i (in_ch.valid),
    .ready_o (in_ch.ready),
    .volt_i  (in_ch.battery_voltage_dv),
    .amps_i  (in_ch.current_limit_da),
    .plug_i  (in_ch.plug_present),
    .bms_i   (in_ch.bms_permits),
    .valid_o (p_valid),
    .ready_i (p_ready),
    .data_o  (p_data)
  );

  cpla_limit_stage u_limit (
    .clk     (clk),
    .rst_n   (rst_n),
    .valid_i (p_valid),
    .ready_o (p_ready),
    .data_i  (p_data),
    .valid_o (l_valid),
    .ready_i (l_ready),
    .data_o  (l_data)
  );

  cpla_scale_stage u_scale (
    .clk        (clk),
    .rst_n      (rst_n),
    .valid_i    (l_valid),
    .ready_o    (l_ready),
    .data_i     (l_data),
    .valid_o    (out_ch.valid),
    .ready_i    (out_ch.ready),
    .setpoint_o (out_ch.power_setpoint_w),
    .reason_o   (out_ch.limit_reason),
    .code_o     (out_ch.charger_code)
  );

  // forced-zero reasons never carry power
  a_zero_reason: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && (out_ch.limit_reason == R_NO_PLUG || out_ch.limit_reason == R_DISABLE ||
                     out_ch.limit_reason == R_BMS || out_ch.limit_reason == R_VOLT)
    |-> out_ch.power_setpoint_w == '0 && out_ch.charger_code == CODE_BASE)
    else $error("forced-zero reason with nonzero setpoint");

  a_code_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> out_ch.charger_code >= CODE_BASE && out_ch.charger_code <= CODE_MAX)
    else $error("charger code out of range");

  // input backpressure only when every stage holds an item
  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> out_ch.valid && !out_ch.ready && l_valid && p_valid)
    else $error("input stalled with a bubble in the pipe");

  a_reset_empty: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_ch.valid && in_ch.ready)
    else $error("pipeline not empty after reset");

endmodule

// ===== bench/tb_charger_power_limit_arbiter_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_charger_power_limit_arbiter_top
// Self-checking bench for the charger power limit arbiter. Requests go in from
// a queue through a clocked driver. Each accepted transfer is scored by an
// in-bench arbitration model, and a clocked monitor compares each result
// transfer field by field. Directed corner requests come first, then random
// batches under changing register settings and changing idle patterns,
// including one long result back-pressure window.
// ----------------------------------------------------------------------------
module tb_charger_power_limit_arbiter_top;
  import cpla_pkg::*;

  localparam int RST_CYCLES    = 7;
  localparam int PIPE_LAT      = 4;
  localparam int SETTLE_CYCLES = 2 * PIPE_LAT + 4;
  localparam int HOLD_CYCLES   = 96;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int BATCHES       = 10;
  localparam int BATCH_ITEMS   = 110;
  localparam int MAX_REPORTS   = 30;

  typedef struct packed {
    logic [FIELD_W-1:0] volt_dv;
    logic [FIELD_W-1:0] amps_da;
    logic               plug;
    logic               bms;
  } request_t;

  typedef struct packed {
    logic [FIELD_W-1:0]  setpoint_w;
    logic [REASON_W-1:0] reason;
    logic [CODE_W-1:0]   code;
  } limit_t;

  logic clk;
  logic rst_n;

  cpla_in_if  in_if ();
  cpla_out_if out_if ();
  cpla_cfg_if cfg_if ();

  charger_power_limit_arbiter_top u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if),
    .cfg_ch (cfg_if)
  );

  // register shadow
  logic               sh_enabled;
  logic [FIELD_W-1:0] sh_ac_w;
  logic [FIELD_W-1:0] sh_vlim_dv;
  logic [FIELD_W-1:0] sh_ceil_w;

  request_t request_q[$];
  limit_t   due_limits_q[$];
  request_t offered;

  int n_queued      = 0;
  int n_accepted    = 0;
  int n_checked     = 0;
  int n_errors      = 0;
  int n_cfg_writes  = 0;
  int n_settings    = 0;
  int cycle_cnt     = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int holds_asked   = 0;
  int holds_done    = 0;
  int hold_left     = 0;
  int reason_seen[7];

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic limit_t arbitrate_power(request_t r);
    int unsigned sp_cw;
    int unsigned dc_cw;
    int unsigned ac_cw;
    int unsigned steps;
    limit_t res;
    sp_cw      = sh_ceil_w * int'(CENTI);
    res.reason = R_HW;
    if (!r.plug) begin
      sp_cw      = 0;
      res.reason = R_NO_PLUG;
    end
    if (!sh_enabled) begin
      sp_cw      = 0;
      res.reason = R_DISABLE;
    end
    if (!r.bms) begin
      sp_cw      = 0;
      res.reason = R_BMS;
    end
    dc_cw = r.volt_dv * r.amps_da;
    if (dc_cw < sp_cw) begin
      sp_cw      = dc_cw;
      res.reason = R_DC;
    end
    ac_cw = sh_ac_w * int'(CENTI);
    if (ac_cw < sp_cw) begin
      sp_cw      = ac_cw;
      res.reason = R_AC;
    end
    if (r.volt_dv >= sh_vlim_dv) begin
      sp_cw      = 0;
      res.reason = R_VOLT;
    end
    steps = sp_cw / (int'(CENTI) * WATTS_PER_STEP);
    if (steps > int'(CODE_MAX - CODE_BASE)) begin
      res.code = CODE_MAX;
    end else begin
      res.code = CODE_BASE + CODE_W'(steps);
    end
    res.setpoint_w = FIELD_W'(sp_cw / int'(CENTI));
    return res;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int good);
    n_errors++;
    if (n_errors <= MAX_REPORTS) begin
      $display("[%0t] mismatch on %s after %0d results: got %0d, wanted %0d",
               $time, what, n_checked, got, good);
    end
  endtask

  task automatic check_limit();
    limit_t want;
    if (due_limits_q.size() == 0) begin
      report_mismatch("unexpected result transfer", out_if.power_setpoint_w, 0);
      return;
    end
    want = due_limits_q.pop_front();
    if (out_if.power_setpoint_w !== want.setpoint_w)
      report_mismatch("power_setpoint_w", out_if.power_setpoint_w, want.setpoint_w);
    if (out_if.limit_reason !== want.reason)
      report_mismatch("limit_reason", out_if.limit_reason, want.reason);
    if (out_if.charger_code !== want.code)
      report_mismatch("charger_code", out_if.charger_code, want.code);
    reason_seen[want.reason]++;
    n_checked++;
  endtask

  // request driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_if.valid <= 1'b0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        due_limits_q.push_back(arbitrate_power(offered));
        n_accepted++;
      end
      if (!in_if.valid || in_if.ready) begin
        if (request_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          offered = request_q.pop_front();
          in_if.battery_voltage_dv <= offered.volt_dv;
          in_if.current_limit_da   <= offered.amps_da;
          in_if.plug_present       <= offered.plug;
          in_if.bms_permits        <= offered.bms;
          in_if.valid              <= 1'b1;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) check_limit();
      out_if.ready <= (hold_left == 0) && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // long back-pressure window
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left  <= 0;
      holds_done <= 0;
    end else if (holds_asked != holds_done) begin
      hold_left  <= HOLD_CYCLES;
      holds_done <= holds_asked;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results checked", cycle_cnt, n_checked);
      $display("status: fail");
      $finish;
    end
  end

  task automatic add_request(input int volt, input int amps, input bit plug, input bit bms);
    request_q.push_back('{FIELD_W'(volt), FIELD_W'(amps), plug, bms});
    n_queued++;
  endtask

  function automatic request_t random_request();
    request_t r;
    int v;
    case ($urandom_range(7))
      0: r.volt_dv = FIELD_W'($urandom);
      1, 2: begin
        v = int'(sh_vlim_dv) + int'($urandom_range(0, 6)) - 3;
        if (v < 0) v = 0;
        if (v > 16383) v = 16383;
        r.volt_dv = FIELD_W'(v);
      end
      default: r.volt_dv = FIELD_W'($urandom_range(0, 10000));
    endcase
    case ($urandom_range(3))
      0: r.amps_da = FIELD_W'($urandom_range(0, 200));
      1: r.amps_da = FIELD_W'($urandom);
      default: r.amps_da = FIELD_W'($urandom_range(0, 10000));
    endcase
    r.plug = ($urandom_range(9) != 0);
    r.bms  = ($urandom_range(9) != 0);
    return r;
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [FIELD_W-1:0] val);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    case (idx)
      REG_CHARGE_ENABLED:     sh_enabled = val[0];
      REG_MAX_AC_POWER_W:     sh_ac_w    = val;
      REG_VOLTAGE_LIMIT_DV:   sh_vlim_dv = val;
      REG_HARDWARE_CEILING_W: sh_ceil_w  = val;
      default: ;
    endcase
    n_cfg_writes++;
  endtask

  task automatic set_config(input logic [FIELD_W-1:0] en, input logic [FIELD_W-1:0] ac,
                            input logic [FIELD_W-1:0] vlim, input logic [FIELD_W-1:0] ceil);
    write_reg(REG_CHARGE_ENABLED, en);
    write_reg(REG_MAX_AC_POWER_W, ac);
    write_reg(REG_VOLTAGE_LIMIT_DV, vlim);
    write_reg(REG_HARDWARE_CEILING_W, ceil);
    cfg_if.valid <= 1'b0;
    n_settings++;
  endtask

  // wait until every accepted request has its result back
  task automatic drain();
    while (n_accepted != n_queued || due_limits_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    logic [FIELD_W-1:0] en_val;
    int b;
    int i;
    rst_n                    = 1'b0;
    in_if.valid              = 1'b0;
    in_if.battery_voltage_dv = '0;
    in_if.current_limit_da   = '0;
    in_if.plug_present       = 1'b0;
    in_if.bms_permits        = 1'b0;
    out_if.ready             = 1'b0;
    cfg_if.valid             = 1'b0;
    cfg_if.index             = '0;
    cfg_if.data              = '0;
    sh_enabled               = 1'b1;
    sh_ac_w                  = RST_MAX_AC_POWER_W;
    sh_vlim_dv               = RST_VOLTAGE_LIMIT_DV;
    sh_ceil_w                = RST_HARDWARE_CEILING_W;
    send_idle_pct            = 34;
    recv_idle_pct            = 71;
    repeat (RST_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // reset defaults
    add_request(0, 0, 0, 0);
    add_request(0, 0, 1, 1);
    add_request(4009, 10000, 1, 1);
    add_request(4010, 10000, 1, 1);
    add_request(16383, 16383, 1, 1);
    add_request(400, 500, 1, 1);      // dc equals ac limit
    add_request(400, 499, 1, 1);
    add_request(3000, 5, 0, 1);
    add_request(3000, 5, 1, 0);
    add_request(3000, 5, 0, 0);
    add_request(3999, 16383, 1, 1);
    drain();

    set_config(14'h0001, 14'h3FFF, 14'd10000, 14'h3FFF);
    add_request(9999, 16383, 1, 1);
    add_request(4300, 381, 1, 1);     // dc equals ceiling
    add_request(4300, 380, 1, 1);
    add_request(3480, 100, 1, 1);     // first saturated code
    add_request(3480, 99, 1, 1);
    add_request(10000, 1, 1, 1);
    drain();

    set_config(14'h3FFE, 14'd5000, 14'd4010, 14'd8000);
    add_request(3000, 100, 1, 1);
    add_request(3000, 100, 0, 1);
    add_request(3000, 100, 1, 0);
    add_request(5000, 100, 1, 1);
    drain();

    set_config(14'h0000, 14'h0000, 14'h0000, 14'h0000);
    add_request(0, 0, 1, 1);
    add_request(8191, 8191, 0, 1);
    drain();

    set_config(14'h0001, 14'h0000, 14'h3FFF, 14'h0000);
    add_request(0, 0, 1, 1);
    add_request(16382, 16383, 1, 1);
    drain();

    for (b = 0; b < BATCHES; b++) begin
      if (b == 4) begin
        send_idle_pct <= 71;
        recv_idle_pct <= 34;
      end
      if (b == 7) begin
        send_idle_pct <= 0;
        recv_idle_pct <= 0;
      end
      case (b)
        0: set_config(14'h0001, 14'h3FFF, 14'h3FFF, 14'h3FFF);
        1: set_config(14'h0001, 14'h0000, 14'd10000, 14'h3FFF);
        default: begin
          en_val    = FIELD_W'($urandom);
          en_val[0] = ($urandom_range(7) != 0);
          set_config(en_val, FIELD_W'($urandom),
                     ($urandom_range(4) == 0) ? FIELD_W'($urandom)
                                              : FIELD_W'($urandom_range(2000, 10000)),
                     FIELD_W'($urandom));
        end
      endcase
      for (i = 0; i < BATCH_ITEMS; i++) begin
        request_q.push_back(random_request());
        n_queued++;
      end
      if (b == 8) holds_asked <= holds_asked + 1;
      drain();
    end

    $display("checked %0d results across %0d register settings (%0d register writes)",
             n_checked, n_settings, n_cfg_writes);
    $display("limit reasons: hw %0d, no plug %0d, disabled %0d, bms %0d, dc %0d, ac %0d, volt %0d",
             reason_seen[R_HW], reason_seen[R_NO_PLUG], reason_seen[R_DISABLE],
             reason_seen[R_BMS], reason_seen[R_DC], reason_seen[R_AC], reason_seen[R_VOLT]);
    if (n_errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
